// ===== rtl/ouvc_pkg.sv =====
// Shared constants, codes and types for the octahedral unit-vector codec.
`default_nettype none

package ouvc_pkg;

    localparam int CODE_W     = 16;
    localparam int DIR_W      = 16;
    localparam int UNIT_W     = 16;
    localparam int MAG_W      = 17;
    localparam int SUM_W      = 17;
    localparam int NU_W       = 18;
    localparam int NUM_W      = 35;
    localparam int SQ_W       = 32;
    localparam int NSUM_W     = 34;
    localparam int ROOT_W     = 64;
    localparam int LEN_W      = 32;
    localparam int DVD_W      = 47;
    localparam int DVS_W      = 32;
    localparam int Q_W        = 16;
    localparam int NORM_SHIFT = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    localparam int LANES      = 3;

    localparam logic [CODE_W-1:0] CODE_MAX = '1;
    localparam logic [CODE_W-1:0] CODE_MID = CODE_W'(1) << (CODE_W - 1);
    localparam logic [UNIT_W-1:0] UNIT_MAX = '1 >> 1;

    typedef enum logic {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    typedef struct packed {
        func_t             func;
        logic              zero;
        logic              sa;
        logic              sb;
        logic [CODE_W-1:0] ma;
        logic [CODE_W-1:0] mb;
        logic [NU_W-1:0]   nu_u;
        logic [NU_W-1:0]   nu_v;
        logic [SUM_W-1:0]  s;
    } front_t;

    typedef struct packed {
        func_t             func;
        logic              zero;
        logic              sa;
        logic              sb;
        logic              sc;
        logic [CODE_W-1:0] ma;
        logic [CODE_W-1:0] mb;
        logic [CODE_W-1:0] mc;
        logic [NUM_W-1:0]  num_u;
        logic [NUM_W-1:0]  num_v;
        logic [NU_W-1:0]   den;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/ouvc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module ouvc_div
    import ouvc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [Q_W-1:0]   quotient
);

    logic [DVD_W-1:0] r_reg [DIV_STEPS];
    logic [DVS_W-1:0] d_reg [DIV_STEPS];
    logic [Q_W-1:0]   q_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DVD_W-1:0] r_in;
        logic [DVS_W-1:0] d_in;
        logic [Q_W-1:0]   q_in;
        logic [DVD_W-1:0] shifted;
        logic             ge;
        logic [DVD_W-1:0] r_next;
        logic [Q_W-1:0]   q_next;

        if (k == 0) begin : g_first
            assign r_in = dividend;
            assign d_in = divisor;
            assign q_in = '0;
        end
        else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        always_comb
        begin
            shifted = DVD_W'(d_in) << (DIV_STEPS - 1 - k);
            ge      = (r_in >= shifted);
            r_next  = ge ? (r_in - shifted) : r_in;
            q_next  = ge ? (q_in | (Q_W'(1) << (DIV_STEPS - 1 - k))) : q_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= r_next;
                d_reg[k] <= d_in;
                q_reg[k] <= q_next;
            end
        end
    end

    assign quotient = q_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/octahedral_unit_vector_codec.sv =====
// Octahedral unit-vector codec: encode a direction to two codes, or decode codes to a unit vector.
//
// Input channel in_valid/in_ready carries func plus both operand sets; func
// selects encode (dir_x/y/z -> out_code_u/v, zero_input) or decode
// (code_u/v -> unit_x/y/z in Q1.15). Fields of the unused operation read zero.
// Output channel out_valid/out_ready carries one result per transaction.
// A transaction reaches out_valid through 54 register stages (the first
// loaded at acceptance): four front stages, a 32-stage square root for
// the decode length, one setup stage, a 16-stage divider (three lanes)
// and the output register.
// Throughput is one transaction per cycle while the output is not stalled;
// the square-root and divider stages each resolve one result bit per cycle.
// A stalled output register freezes the whole pipeline; in_ready falls in
// the same cycle and nothing is dropped or repeated.
// Reset clears every valid bit; the pipeline is empty and in_ready is high.
`default_nettype none

module octahedral_unit_vector_codec
    import ouvc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [DIR_W-1:0]  dir_x,
    input  wire logic [DIR_W-1:0]  dir_y,
    input  wire logic [DIR_W-1:0]  dir_z,
    input  wire logic [CODE_W-1:0] code_u,
    input  wire logic [CODE_W-1:0] code_v,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CODE_W-1:0] out_code_u,
    output logic      [CODE_W-1:0] out_code_v,
    output logic      [UNIT_W-1:0] unit_x,
    output logic      [UNIT_W-1:0] unit_y,
    output logic      [UNIT_W-1:0] unit_z,
    output logic                   zero_input
);

    function automatic logic [UNIT_W-1:0] to_unit(logic [Q_W-1:0] q, logic neg);
        logic [UNIT_W-1:0] sat;
        sat = (q > Q_W'(UNIT_MAX)) ? UNIT_MAX : UNIT_W'(q);
        return neg ? UNIT_W'(-sat) : sat;
    endfunction

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: magnitudes, L1 sum, fold selection, decode code offsets
    logic   v1_reg;
    front_t f1_reg;
    front_t f1_next;

    always_comb
    begin
        logic [MAG_W-1:0] xs, ys, zs, ax, ay, az;
        logic [SUM_W-1:0] s;
        logic [NU_W-1:0]  two_s;
        xs = {dir_x[DIR_W-1], dir_x};
        ys = {dir_y[DIR_W-1], dir_y};
        zs = {dir_z[DIR_W-1], dir_z};
        ax = xs[MAG_W-1] ? (~xs + MAG_W'(1)) : xs;
        ay = ys[MAG_W-1] ? (~ys + MAG_W'(1)) : ys;
        az = zs[MAG_W-1] ? (~zs + MAG_W'(1)) : zs;
        s  = ax + ay + az;
        two_s = {s, 1'b0};
        f1_next.func = func_t'(func);
        f1_next.zero = (s == '0);
        f1_next.s    = s;
        if (!dir_z[DIR_W-1])
        begin
            f1_next.nu_u = NU_W'({{2{dir_x[DIR_W-1]}}, dir_x}) + NU_W'(s);
            f1_next.nu_v = NU_W'({{2{dir_y[DIR_W-1]}}, dir_y}) + NU_W'(s);
        end
        else
        begin
            f1_next.nu_u = dir_x[DIR_W-1] ? NU_W'(ay) : (two_s - NU_W'(ay));
            f1_next.nu_v = dir_y[DIR_W-1] ? NU_W'(ax) : (two_s - NU_W'(ax));
        end
        f1_next.sa = !code_u[CODE_W-1];
        f1_next.sb = !code_v[CODE_W-1];
        f1_next.ma = code_u[CODE_W-1] ? CODE_W'({code_u, 1'b0} - {1'b0, CODE_MAX})
                                      : CODE_W'({1'b0, CODE_MAX} - {code_u, 1'b0});
        f1_next.mb = code_v[CODE_W-1] ? CODE_W'({code_v, 1'b0} - {1'b0, CODE_MAX})
                                      : CODE_W'({1'b0, CODE_MAX} - {code_v, 1'b0});
    end

    // stage 2: quantizer numerators, decode z and unfold
    logic  v2_reg;
    side_t sd2_reg;
    side_t sd2_next;

    always_comb
    begin
        logic [CODE_W+1:0] c;
        logic              cneg;
        c    = {2'b00, CODE_MAX} - {2'b00, f1_reg.ma} - {2'b00, f1_reg.mb};
        cneg = c[CODE_W+1];
        sd2_next.func  = f1_reg.func;
        sd2_next.zero  = f1_reg.zero;
        sd2_next.sa    = f1_reg.sa;
        sd2_next.sb    = f1_reg.sb;
        sd2_next.sc    = cneg;
        sd2_next.mc    = cneg ? CODE_W'(-c) : CODE_W'(c);
        sd2_next.ma    = cneg ? (CODE_MAX - f1_reg.mb) : f1_reg.ma;
        sd2_next.mb    = cneg ? (CODE_MAX - f1_reg.ma) : f1_reg.mb;
        sd2_next.num_u = (NUM_W'(f1_reg.nu_u) << CODE_W) - NUM_W'(f1_reg.nu_u)
                         + NUM_W'(f1_reg.s);
        sd2_next.num_v = (NUM_W'(f1_reg.nu_v) << CODE_W) - NUM_W'(f1_reg.nu_v)
                         + NUM_W'(f1_reg.s);
        sd2_next.den   = NU_W'({f1_reg.s, 1'b0});
    end

    // stage 3: squares
    logic            v3_reg;
    side_t           sd3_reg;
    logic [SQ_W-1:0] sqa_reg, sqb_reg, sqc_reg;

    // stage 4: squared length, scaled for the root
    logic              v4_reg;
    side_t             sd4_reg;
    logic [ROOT_W-1:0] n4_reg;
    logic [NSUM_W-1:0] nsum;

    assign nsum = NSUM_W'(sqa_reg) + NSUM_W'(sqb_reg) + NSUM_W'(sqc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg  <= f1_next;
            sd2_reg <= sd2_next;
            sd3_reg <= sd2_reg;
            sqa_reg <= sd2_reg.ma * sd2_reg.ma;
            sqb_reg <= sd2_reg.mb * sd2_reg.mb;
            sqc_reg <= sd2_reg.mc * sd2_reg.mc;
            sd4_reg <= sd3_reg;
            n4_reg  <= ROOT_W'(nsum) << NORM_SHIFT;
        end
    end

    // square root, one result bit per stage
    logic              iv_reg  [SQRT_STEPS];
    side_t             isd_reg [SQRT_STEPS];
    logic [ROOT_W-1:0] in_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] ir_reg  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic              v_in;
        side_t             sd_in;
        logic [ROOT_W-1:0] n_in;
        logic [ROOT_W-1:0] r_in;
        logic [ROOT_W-1:0] trial;
        logic              take;
        logic [ROOT_W-1:0] n_next;
        logic [ROOT_W-1:0] r_next;

        if (k == 0) begin : g_first
            assign v_in  = v4_reg;
            assign sd_in = sd4_reg;
            assign n_in  = n4_reg;
            assign r_in  = '0;
        end
        else begin : g_rest
            assign v_in  = iv_reg[k-1];
            assign sd_in = isd_reg[k-1];
            assign n_in  = in_reg[k-1];
            assign r_in  = ir_reg[k-1];
        end

        always_comb
        begin
            trial  = r_in + (ROOT_W'(1) << (ROOT_W - 2 - 2 * k));
            take   = (n_in >= trial);
            n_next = take ? (n_in - trial) : n_in;
            r_next = take ? ((r_in >> 1) + (ROOT_W'(1) << (ROOT_W - 2 - 2 * k)))
                          : (r_in >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                iv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                iv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                isd_reg[k] <= sd_in;
                in_reg[k]  <= n_next;
                ir_reg[k]  <= r_next;
            end
        end
    end

    // divider operands
    side_t            sdr;
    logic [LEN_W-1:0] len;
    logic             v5_reg;
    side_t            sd5_reg;
    logic [DVD_W-1:0] dvd_reg  [LANES];
    logic [DVS_W-1:0] dvs_reg  [LANES];
    logic [DVD_W-1:0] dvd_next [LANES];
    logic [DVS_W-1:0] dvs_next [LANES];

    assign sdr = isd_reg[SQRT_STEPS-1];
    assign len = LEN_W'(ir_reg[SQRT_STEPS-1]);

    always_comb
    begin
        logic [DVD_W-1:0] half;
        half = DVD_W'(len >> 1);
        if (sdr.func == FUNC_DECODE)
        begin
            dvd_next[0] = (DVD_W'(sdr.ma) << NORM_SHIFT) + half;
            dvd_next[1] = (DVD_W'(sdr.mb) << NORM_SHIFT) + half;
            dvd_next[2] = (DVD_W'(sdr.mc) << NORM_SHIFT) + half;
            dvs_next[0] = len;
            dvs_next[1] = len;
            dvs_next[2] = len;
        end
        else
        begin
            dvd_next[0] = DVD_W'(sdr.num_u);
            dvd_next[1] = DVD_W'(sdr.num_v);
            dvd_next[2] = '0;
            dvs_next[0] = DVS_W'(sdr.den);
            dvs_next[1] = DVS_W'(sdr.den);
            dvs_next[2] = DVS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= iv_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd5_reg <= sdr;
            for (int j = 0; j < LANES; j++)
            begin
                dvd_reg[j] <= dvd_next[j];
                dvs_reg[j] <= dvs_next[j];
            end
        end
    end

    logic [Q_W-1:0] quo [LANES];

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        ouvc_div u_div (
            .clk      (clk),
            .en       (en),
            .dividend (dvd_reg[j]),
            .divisor  (dvs_reg[j]),
            .quotient (quo[j])
        );
    end

    // sideband alongside the divider
    logic  dv_reg  [DIV_STEPS];
    side_t dsd_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dside
        logic  v_in;
        side_t sd_in;

        if (k == 0) begin : g_first
            assign v_in  = v5_reg;
            assign sd_in = sd5_reg;
        end
        else begin : g_rest
            assign v_in  = dv_reg[k-1];
            assign sd_in = dsd_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dsd_reg[k] <= sd_in;
            end
        end
    end

    // output register
    side_t             sdo;
    logic [CODE_W-1:0] out_code_u_reg, out_code_u_next;
    logic [CODE_W-1:0] out_code_v_reg, out_code_v_next;
    logic [UNIT_W-1:0] unit_x_reg, unit_x_next;
    logic [UNIT_W-1:0] unit_y_reg, unit_y_next;
    logic [UNIT_W-1:0] unit_z_reg, unit_z_next;
    logic              zero_input_reg, zero_input_next;

    assign sdo = dsd_reg[DIV_STEPS-1];

    always_comb
    begin
        out_code_u_next = '0;
        out_code_v_next = '0;
        unit_x_next     = '0;
        unit_y_next     = '0;
        unit_z_next     = '0;
        zero_input_next = 1'b0;
        if (sdo.func == FUNC_DECODE)
        begin
            unit_x_next = to_unit(quo[0], sdo.sa);
            unit_y_next = to_unit(quo[1], sdo.sb);
            unit_z_next = to_unit(quo[2], sdo.sc);
        end
        else if (sdo.zero)
        begin
            out_code_u_next = CODE_MID;
            out_code_v_next = CODE_MID;
            zero_input_next = 1'b1;
        end
        else
        begin
            out_code_u_next = CODE_W'(quo[0]);
            out_code_v_next = CODE_W'(quo[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_code_u_reg <= out_code_u_next;
            out_code_v_reg <= out_code_v_next;
            unit_x_reg     <= unit_x_next;
            unit_y_reg     <= unit_y_next;
            unit_z_reg     <= unit_z_next;
            zero_input_reg <= zero_input_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_code_u = out_code_u_reg;
    assign out_code_v = out_code_v_reg;
    assign unit_x     = unit_x_reg;
    assign unit_y     = unit_y_reg;
    assign unit_z     = unit_z_reg;
    assign zero_input = zero_input_reg;

    a_zero_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_input |-> out_code_u == CODE_MID && out_code_v == CODE_MID)
        else $error("zero direction without midpoint codes");

    a_decode_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (unit_x != '0 || unit_y != '0 || unit_z != '0)
        |-> out_code_u == '0 && out_code_v == '0 && !zero_input)
        else $error("decode transaction carries encode fields");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x != ~(UNIT_MAX) && unit_y != ~(UNIT_MAX)
                      && unit_z != ~(UNIT_MAX))
        else $error("unit component beyond saturation");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(v5_reg) && $stable(dv_reg[0]))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
